// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and reset.
`define FOR_ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked assertion on clk, disabled while rst_n is low.
`define FOR_ASSERT(label, prop, msg) \
  `FOR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ----- rtl/for_pkg.sv -----
// ---------------------------------------------------------------------------
// for_pkg
// Shared types and constants of the fuzzy option ranker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package for_pkg;

  localparam int CHAR_W     = 21;
  localparam int SCORE_W    = 14;
  localparam int IDX_W      = 5;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 14'h3FFF;
  localparam logic [SCORE_W-1:0] POS_BONUS = 14'd80;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_OPTION = 2'd2;
  localparam logic [OP_W-1:0] OP_RANK   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_Q,
    ST_OPT_END,
    ST_SCAN_R,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_CLR,
    ALU_ACC,
    ALU_RANK_INIT,
    ALU_RANK_STEP,
    ALU_RANK_NEXT
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    pos_hit;
  } alu_cmd_t;

  typedef struct packed {
    logic               vld;
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic               last;
    logic               none;
  } emit_t;

endpackage

`default_nettype wire

// ----- rtl/fuzzy_option_ranker.sv -----
// ---------------------------------------------------------------------------
// Fuzzy option ranker
// Scores option names against a query string and emits them ranked.
// ---------------------------------------------------------------------------
// Input beats (in_*): tuser carries the operation (clear, query char, option
// char, rank), tdata the code point and tlast marks an option's final char.
// Clear and query beats may arrive back to back.
// An option char walks the stored query through one compare/add unit, one
// query entry per cycle; the walk is skipped when the query is empty or the
// name is past its length limit.
// A rank beat runs one selection pass per stored option over the score
// memory and hands each pass's result to the output register. With no
// option stored it gives one result flagged by out_tuser.
// out_tlast marks the last result of a ranking run.
// in_tready is low while an item is in progress. The output register holds
// a result while out_tready is low; a ranking pass then waits for it.
// Reset (rst_n low, synchronous) empties the query and option table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_option_ranker #(
  parameter int MAX_QUERY   = 64,
  parameter int MAX_NAME    = 64,
  parameter int MAX_OPTIONS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [for_pkg::IN_DATA_W-1:0]     in_tdata,   // [20:0] char_value
  input  wire logic [for_pkg::OP_W-1:0]          in_tuser,   // [1:0] operation
  input  wire logic                              in_tlast,   // last_char
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [for_pkg::OUT_DATA_W-1:0]    out_tdata,  // [4:0] option_index, [18:5] score
  output logic                                   out_tuser,  // [0] none
  output logic                                   out_tlast   // final_res
);

  localparam int QA_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int OA_W = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
  localparam int CW   = for_pkg::CHAR_W;
  localparam int SW   = for_pkg::SCORE_W;
  localparam int PAD  = for_pkg::OUT_DATA_W - for_pkg::IDX_W - SW;

  logic                 q_we, s_we;
  logic [QA_W-1:0]      q_waddr, q_raddr;
  logic [OA_W-1:0]      s_waddr, s_raddr;
  logic [CW-1:0]        q_rdata;
  logic [SW-1:0]        s_rdata;
  logic [CW-1:0]        cur_char;
  logic [OA_W-1:0]      rd_idx;
  logic [SW-1:0]        run_score, best_score;
  logic [OA_W-1:0]      best_idx;
  for_pkg::alu_cmd_t    alu_cmd;
  for_pkg::emit_t       emit;
  logic                 out_free;

  logic                           out_vld_r, out_vld_nxt;
  logic [for_pkg::IDX_W-1:0]      out_idx_r;
  logic [SW-1:0]                  out_score_r;
  logic                           out_last_r;
  logic                           out_none_r;

  for_ctrl #(
    .MAX_QUERY   (MAX_QUERY),
    .MAX_NAME    (MAX_NAME),
    .MAX_OPTIONS (MAX_OPTIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_char    (in_tdata[CW-1:0]),
    .in_last    (in_tlast),
    .q_we       (q_we),
    .q_waddr    (q_waddr),
    .q_raddr    (q_raddr),
    .s_we       (s_we),
    .s_waddr    (s_waddr),
    .s_raddr    (s_raddr),
    .alu_cmd    (alu_cmd),
    .cur_char   (cur_char),
    .rd_idx     (rd_idx),
    .best_score (best_score),
    .best_idx   (best_idx),
    .emit       (emit),
    .out_free   (out_free)
  );

  for_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_QUERY),
    .AW    (QA_W)
  ) u_qmem (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_tdata[CW-1:0]),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  for_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_OPTIONS),
    .AW    (OA_W)
  ) u_smem (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (run_score),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  for_alu #(
    .IDX_W (OA_W)
  ) u_alu (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (alu_cmd),
    .q_char     (q_rdata),
    .c_char     (cur_char),
    .rd_score   (s_rdata),
    .rd_idx     (rd_idx),
    .run_score  (run_score),
    .best_score (best_score),
    .best_idx   (best_idx)
  );

  // Output register: a new result loads when the register is empty or its
  // beat is being taken in the same cycle.
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit.vld && out_free) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.vld && out_free) begin
      out_idx_r   <= emit.idx;
      out_score_r <= emit.score;
      out_last_r  <= emit.last;
      out_none_r  <= emit.none;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{PAD{1'b0}}, out_score_r, out_idx_r};
  assign out_tuser  = out_none_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/for_ram.sv -----
// ---------------------------------------------------------------------------
// for_ram
// Simple dual-port memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module for_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/for_alu.sv -----
// ---------------------------------------------------------------------------
// for_alu
// Shared compare and saturating-add unit for scoring and ranking.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module for_alu #(
  parameter int IDX_W = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire for_pkg::alu_cmd_t             cmd,
  input  wire logic [for_pkg::CHAR_W-1:0]    q_char,
  input  wire logic [for_pkg::CHAR_W-1:0]    c_char,
  input  wire logic [for_pkg::SCORE_W-1:0]   rd_score,
  input  wire logic [IDX_W-1:0]              rd_idx,
  output logic      [for_pkg::SCORE_W-1:0]   run_score,
  output logic      [for_pkg::SCORE_W-1:0]   best_score,
  output logic      [IDX_W-1:0]              best_idx
);

  localparam int SW = for_pkg::SCORE_W;

  logic [SW-1:0]    run_r, run_nxt;
  logic             best_vld_r, best_vld_nxt;
  logic [SW-1:0]    best_score_r, best_score_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             prev_vld_r, prev_vld_nxt;
  logic [SW-1:0]    prev_score_r, prev_score_nxt;
  logic [IDX_W-1:0] prev_idx_r, prev_idx_nxt;

  logic          char_eq;
  logic [SW-1:0] inc;
  logic [SW:0]   sum;
  logic [SW-1:0] sat_sum;
  logic          qualify;
  logic          better;

  assign char_eq = (q_char == c_char);
  assign inc     = cmd.pos_hit ? (for_pkg::POS_BONUS + SW'(1)) : SW'(1);
  assign sum     = {1'b0, run_r} + {1'b0, inc};
  assign sat_sum = (sum > {1'b0, for_pkg::SCORE_MAX}) ? for_pkg::SCORE_MAX : sum[SW-1:0];

  // A candidate is still unranked when it sorts after the previously emitted
  // option: lower score, or equal score with a higher index.
  assign qualify = !prev_vld_r || (rd_score < prev_score_r) ||
                   ((rd_score == prev_score_r) && (rd_idx > prev_idx_r));
  assign better  = !best_vld_r || (rd_score > best_score_r);

  always_comb begin
    run_nxt        = run_r;
    best_vld_nxt   = best_vld_r;
    best_score_nxt = best_score_r;
    best_idx_nxt   = best_idx_r;
    prev_vld_nxt   = prev_vld_r;
    prev_score_nxt = prev_score_r;
    prev_idx_nxt   = prev_idx_r;
    unique case (cmd.op)
      for_pkg::ALU_NOP: begin
      end
      for_pkg::ALU_CLR: begin
        run_nxt = '0;
      end
      for_pkg::ALU_ACC: begin
        if (char_eq) begin
          run_nxt = sat_sum;
        end
      end
      for_pkg::ALU_RANK_INIT: begin
        prev_vld_nxt = 1'b0;
        best_vld_nxt = 1'b0;
      end
      for_pkg::ALU_RANK_STEP: begin
        if (qualify && better) begin
          best_vld_nxt   = 1'b1;
          best_score_nxt = rd_score;
          best_idx_nxt   = rd_idx;
        end
      end
      for_pkg::ALU_RANK_NEXT: begin
        prev_vld_nxt   = 1'b1;
        prev_score_nxt = best_score_r;
        prev_idx_nxt   = best_idx_r;
        best_vld_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= '0;
      best_vld_r <= 1'b0;
      prev_vld_r <= 1'b0;
    end else begin
      run_r      <= run_nxt;
      best_vld_r <= best_vld_nxt;
      prev_vld_r <= prev_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_score_r <= best_score_nxt;
    best_idx_r   <= best_idx_nxt;
    prev_score_r <= prev_score_nxt;
    prev_idx_r   <= prev_idx_nxt;
  end

  assign run_score  = run_r;
  assign best_score = best_score_r;
  assign best_idx   = best_idx_r;

endmodule

`default_nettype wire

// ----- rtl/for_ctrl.sv -----
// ---------------------------------------------------------------------------
// for_ctrl
// Sequencer: query/option bookkeeping, memory scans and ranking passes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module for_ctrl #(
  parameter  int MAX_QUERY   = 64,
  parameter  int MAX_NAME    = 64,
  parameter  int MAX_OPTIONS = 32,
  localparam int QL_W  = $clog2(MAX_QUERY + 1),
  localparam int QA_W  = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1,
  localparam int OC_W  = $clog2(MAX_OPTIONS + 1),
  localparam int OA_W  = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [for_pkg::OP_W-1:0]      in_op,
  input  wire logic [for_pkg::CHAR_W-1:0]    in_char,
  input  wire logic                          in_last,
  output logic                               q_we,
  output logic      [QA_W-1:0]               q_waddr,
  output logic      [QA_W-1:0]               q_raddr,
  output logic                               s_we,
  output logic      [OA_W-1:0]               s_waddr,
  output logic      [OA_W-1:0]               s_raddr,
  output for_pkg::alu_cmd_t                  alu_cmd,
  output logic      [for_pkg::CHAR_W-1:0]    cur_char,
  output logic      [OA_W-1:0]               rd_idx,
  input  wire logic [for_pkg::SCORE_W-1:0]   best_score,
  input  wire logic [OA_W-1:0]               best_idx,
  output for_pkg::emit_t                     emit,
  input  wire logic                          out_free
);

  localparam int NP_W      = $clog2(MAX_NAME + 1);
  localparam int CNT_W     = (QL_W > OC_W) ? QL_W : OC_W;
  localparam int CMP_W     = (CNT_W > NP_W) ? CNT_W : NP_W;
  localparam int OUT_IDX_W = for_pkg::IDX_W;

  for_pkg::state_t state_r, state_nxt;

  logic [QL_W-1:0]             qlen_r, qlen_nxt;
  logic [OC_W-1:0]             ocnt_r, ocnt_nxt;
  logic [NP_W-1:0]             npos_r, npos_nxt;
  logic [for_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic [CNT_W-1:0]            iss_r, iss_nxt;
  logic                        p_vld_r;
  logic [CNT_W-1:0]            p_idx_r;
  logic [OC_W-1:0]             rank_r, rank_nxt;

  logic             accept;
  logic             scanning;
  logic [CNT_W-1:0] scan_lim;
  logic             issuing;
  logic             scan_done;
  logic             emit_last;
  logic             q_room;
  logic             s_room;
  logic             name_room;

  assign accept    = in_valid && in_ready;
  assign scanning  = (state_r == for_pkg::ST_SCAN_Q) || (state_r == for_pkg::ST_SCAN_R);
  assign scan_lim  = (state_r == for_pkg::ST_SCAN_Q) ? CNT_W'(qlen_r) : CNT_W'(ocnt_r);
  assign issuing   = scanning && (iss_r < scan_lim);
  assign scan_done = !issuing && !p_vld_r;
  assign q_room    = (qlen_r < QL_W'(MAX_QUERY));
  assign s_room    = (ocnt_r < OC_W'(MAX_OPTIONS));
  assign name_room = (npos_r < NP_W'(MAX_NAME));
  assign emit_last = (ocnt_r == '0) ||
                     (({1'b0, rank_r} + (OC_W+1)'(1)) == {1'b0, ocnt_r});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      for_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == for_pkg::OP_OPTION) begin
            state_nxt = (name_room && (qlen_r != '0)) ? for_pkg::ST_SCAN_Q
                                                       : for_pkg::ST_OPT_END;
          end else if (in_op == for_pkg::OP_RANK) begin
            state_nxt = (ocnt_r == '0) ? for_pkg::ST_EMIT : for_pkg::ST_SCAN_R;
          end
        end
      end
      for_pkg::ST_SCAN_Q: begin
        if (scan_done) begin
          state_nxt = for_pkg::ST_OPT_END;
        end
      end
      for_pkg::ST_OPT_END: begin
        state_nxt = for_pkg::ST_IDLE;
      end
      for_pkg::ST_SCAN_R: begin
        if (scan_done) begin
          state_nxt = for_pkg::ST_EMIT;
        end
      end
      for_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = emit_last ? for_pkg::ST_IDLE : for_pkg::ST_SCAN_R;
        end
      end
      default: state_nxt = for_pkg::ST_IDLE;
    endcase
  end

  // Outputs toward memories, the shared unit and the output stage.
  always_comb begin
    in_ready         = (state_r == for_pkg::ST_IDLE);
    q_we             = 1'b0;
    s_we             = 1'b0;
    alu_cmd.op       = for_pkg::ALU_NOP;
    alu_cmd.pos_hit  = (CMP_W'(p_idx_r) == CMP_W'(npos_r));
    emit.vld         = 1'b0;
    emit.none        = (ocnt_r == '0);
    emit.last        = emit_last;
    emit.idx         = (ocnt_r == '0) ? '0 : OUT_IDX_W'(best_idx);
    emit.score       = (ocnt_r == '0) ? '0 : best_score;
    unique case (state_r)
      for_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == for_pkg::OP_CLEAR) begin
            alu_cmd.op = for_pkg::ALU_CLR;
          end else if (in_op == for_pkg::OP_QUERY) begin
            q_we = q_room;
          end else if (in_op == for_pkg::OP_RANK) begin
            alu_cmd.op = for_pkg::ALU_RANK_INIT;
          end
        end
      end
      for_pkg::ST_SCAN_Q: begin
        if (p_vld_r) begin
          alu_cmd.op = for_pkg::ALU_ACC;
        end
      end
      for_pkg::ST_OPT_END: begin
        if (last_r) begin
          s_we       = s_room;
          alu_cmd.op = for_pkg::ALU_CLR;
        end
      end
      for_pkg::ST_SCAN_R: begin
        if (p_vld_r) begin
          alu_cmd.op = for_pkg::ALU_RANK_STEP;
        end
      end
      for_pkg::ST_EMIT: begin
        emit.vld = 1'b1;
        if (out_free && !emit_last) begin
          alu_cmd.op = for_pkg::ALU_RANK_NEXT;
        end
      end
      default: begin
      end
    endcase
  end

  // Counters and captured item fields.
  always_comb begin
    qlen_nxt = qlen_r;
    ocnt_nxt = ocnt_r;
    npos_nxt = npos_r;
    char_nxt = char_r;
    last_nxt = last_r;
    rank_nxt = rank_r;
    iss_nxt  = scanning ? (issuing ? iss_r + CNT_W'(1) : iss_r) : '0;
    if (accept) begin
      unique case (in_op)
        for_pkg::OP_CLEAR: begin
          qlen_nxt = '0;
          ocnt_nxt = '0;
          npos_nxt = '0;
        end
        for_pkg::OP_QUERY: begin
          if (q_room) begin
            qlen_nxt = qlen_r + QL_W'(1);
          end
        end
        for_pkg::OP_OPTION: begin
          char_nxt = in_char;
          last_nxt = in_last;
        end
        for_pkg::OP_RANK: begin
          rank_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (state_r == for_pkg::ST_OPT_END) begin
      if (name_room) begin
        npos_nxt = npos_r + NP_W'(1);
      end
      if (last_r) begin
        npos_nxt = '0;
        if (s_room) begin
          ocnt_nxt = ocnt_r + OC_W'(1);
        end
      end
    end
    if ((state_r == for_pkg::ST_EMIT) && out_free && !emit_last) begin
      rank_nxt = rank_r + OC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= for_pkg::ST_IDLE;
      qlen_r  <= '0;
      ocnt_r  <= '0;
      npos_r  <= '0;
      iss_r   <= '0;
      p_vld_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      state_r <= state_nxt;
      qlen_r  <= qlen_nxt;
      ocnt_r  <= ocnt_nxt;
      npos_r  <= npos_nxt;
      iss_r   <= iss_nxt;
      p_vld_r <= issuing;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    last_r  <= last_nxt;
    p_idx_r <= iss_r;
  end

  assign q_waddr  = qlen_r[QA_W-1:0];
  assign q_raddr  = iss_r[QA_W-1:0];
  assign s_waddr  = ocnt_r[OA_W-1:0];
  assign s_raddr  = iss_r[OA_W-1:0];
  assign rd_idx   = p_idx_r[OA_W-1:0];
  assign cur_char = char_r;

endmodule

`default_nettype wire

// ----- rtl/for_chk.sv -----
// ---------------------------------------------------------------------------
// for_chk
// Port-level checks of the fuzzy option ranker, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module for_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [for_pkg::OP_W-1:0]       in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [for_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                           out_tuser,
  input wire logic                           out_tlast
);

  logic in_beat;
  logic short_op;

  assign in_beat  = in_tvalid && in_tready;
  assign short_op = (in_tuser == for_pkg::OP_CLEAR) || (in_tuser == for_pkg::OP_QUERY);

  // A stalled result beat keeps its contents.
  `FOR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "result beat changed while stalled")

  // A taken rank beat always leaves the block busy, with in_tready low.
  `FOR_ASSERT(a_rank_busy, in_beat && (in_tuser == for_pkg::OP_RANK) |=> !in_tready, "ready right after a rank beat")

  // Clear and query beats complete in the cycle they are taken.
  `FOR_ASSERT(a_short_ready, in_beat && short_op |=> in_tready, "not ready after clear or query beat")

  // The empty-table result is a lone, zeroed, final beat.
  `FOR_ASSERT(a_none_form, out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0), "malformed empty-table result")

endmodule

bind fuzzy_option_ranker for_chk u_for_chk (.*);

`default_nettype wire
